// File: hdl/sdinit_pkg.sv
// Shared types and constants for the SD card initialization sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sdinit_pkg;

  localparam int RetryCntW = 16;
  localparam int RetryCmpW = (RetryCntW > 16) ? RetryCntW : 16;
  localparam logic [RetryCntW-1:0] RetryMax = '1;
  localparam logic [15:0] RetryLimitRst = 16'd1000;

  localparam logic [31:0] IfPattern = 32'h0000_01AA;
  localparam logic [31:0] IfMask = 32'h0000_0FFF;
  localparam logic [31:0] OpArg = 32'h40FF_8000;
  localparam int OcrBusyBit = 31;
  localparam int OcrCcsBit = 30;
  localparam logic [31:0] XcThreshold = 32'd67108864;
  localparam int BlockShift = 9;

  localparam logic [5:0] CmdGoIdle = 6'd0;
  localparam logic [5:0] CmdSendIf = 6'd8;
  localparam logic [5:0] CmdAppCmd = 6'd55;
  localparam logic [5:0] CmdSdSendOp = 6'd41;
  localparam logic [5:0] CmdAllSendCid = 6'd2;
  localparam logic [5:0] CmdSendRca = 6'd3;
  localparam logic [5:0] CmdSendCsd = 6'd9;
  localparam logic [5:0] CmdSelect = 6'd7;

  localparam logic [1:0] CsdV1 = 2'd0;
  localparam logic [1:0] CsdV2 = 2'd1;

  typedef enum logic [1:0] {
    ActStart  = 2'd0,
    ActRsp    = 2'd1,
    ActAccess = 2'd2,
    ActDeinit = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StInitFail = 3'd1,
    StBadState = 3'd2,
    StBadArg   = 3'd3,
    StRange    = 3'd4,
    StBus      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KindUnknown = 2'd0,
    KindSdsc    = 2'd1,
    KindSdhc    = 2'd2,
    KindSdxc    = 2'd3
  } kind_e;

  typedef enum logic [9:0] {
    PhIdle   = 10'b00_0000_0001,
    PhCmd0   = 10'b00_0000_0010,
    PhCmd8   = 10'b00_0000_0100,
    PhCmd55  = 10'b00_0000_1000,
    PhAcmd41 = 10'b00_0001_0000,
    PhCmd2   = 10'b00_0010_0000,
    PhCmd3   = 10'b00_0100_0000,
    PhCmd9   = 10'b00_1000_0000,
    PhCmd7   = 10'b01_0000_0000,
    PhReady  = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    action_e     action;
    logic        rsp_error;
    logic [31:0] rsp_word0;
    logic [31:0] rsp_word1;
    logic [31:0] rsp_word2;
    logic [31:0] rsp_word3;
    logic [31:0] lba;
    logic [31:0] block_count;
    logic        is_write;
  } item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    status_e     status;
    logic        init_done;
    kind_e       card_kind;
    logic [31:0] capacity;
    logic [15:0] card_rca;
    logic [31:0] card_address;
    logic        access_write;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/sdinit_in_reg.sv
// Input register stage of the SD card initialization sequencer.
// Depends on sdinit_pkg for the word type.
`default_nettype none

module sdinit_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sdinit_pkg::item_t item_i,
  input  wire logic              down_ready_i,
  output logic                   valid_o,
  output sdinit_pkg::item_t      item_o
);

  logic              valid_q;
  sdinit_pkg::item_t item_q;
  logic              take;

  assign in_ready_o = !valid_q || down_ready_i;
  assign take = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

// File: hdl/sdinit_core.sv
// Sequencer state and the single-pass decision logic for one word.
// Depends on sdinit_pkg for types, command codes and constants.
`default_nettype none

module sdinit_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              fire_i,
  input  wire sdinit_pkg::item_t item_i,
  output sdinit_pkg::result_t    res_o
);

  localparam int CntW = sdinit_pkg::RetryCntW;
  localparam int CmpW = sdinit_pkg::RetryCmpW;

  logic [15:0]          limit_q;
  sdinit_pkg::phase_e   phase_q, phase_d;
  logic [CntW-1:0]      rc_q, rc_d;
  logic [15:0]          rca_q, rca_d;
  logic [31:0]          cap_q, cap_d;
  logic                 hc_q, hc_d;
  sdinit_pkg::kind_e    kind_q, kind_d;

  logic        drop;
  logic        restart;
  logic        ready_d;
  logic [CntW-1:0] rc_inc;
  logic        retry_out;

  logic [11:0] c_size0;
  logic [3:0]  bl_len;
  logic [2:0]  mult;
  logic [4:0]  sh0;
  logic [31:0] bytes0;
  logic [31:0] blocks0;
  logic [21:0] c_size1;
  logic [31:0] blocks1;
  logic [32:0] range_end;

  assign c_size0 = {item_i.rsp_word2[9:0], item_i.rsp_word1[31:30]};
  assign bl_len = item_i.rsp_word2[19:16];
  assign mult = item_i.rsp_word1[17:15];
  assign sh0 = 5'(mult) + 5'd2 + 5'(bl_len);
  assign bytes0 = ({20'b0, c_size0} + 32'd1) << sh0;
  assign blocks0 = bytes0 >> sdinit_pkg::BlockShift;
  assign c_size1 = {item_i.rsp_word2[5:0], item_i.rsp_word1[31:16]} + 22'd1;
  assign blocks1 = {c_size1, 10'b0};

  assign rc_inc = (rc_q != sdinit_pkg::RetryMax) ? rc_q + 1'b1 : rc_q;
  assign retry_out = (CmpW'(rc_inc) >= CmpW'(limit_q)) || (rc_inc == sdinit_pkg::RetryMax);
  assign range_end = {1'b0, item_i.lba} + {1'b0, item_i.block_count};

  always_comb begin
    phase_d = phase_q;
    rc_d = rc_q;
    rca_d = rca_q;
    cap_d = cap_q;
    hc_d = hc_q;
    kind_d = kind_q;
    drop = 1'b0;
    restart = 1'b0;
    res_o = '0;
    res_o.status = sdinit_pkg::StOk;
    res_o.card_kind = sdinit_pkg::KindUnknown;

    case (item_i.action)
      sdinit_pkg::ActStart: begin
        if (phase_q == sdinit_pkg::PhReady) begin
          res_o.status = sdinit_pkg::StBadState;
        end else begin
          drop = 1'b1;
          restart = 1'b1;
          res_o.cmd_valid = 1'b1;
          res_o.cmd_index = sdinit_pkg::CmdGoIdle;
        end
      end
      sdinit_pkg::ActRsp: begin
        if (phase_q inside {sdinit_pkg::PhIdle, sdinit_pkg::PhReady}) begin
          res_o.status = sdinit_pkg::StBadState;
        end else if (item_i.rsp_error) begin
          res_o.status = sdinit_pkg::StBus;
          drop = 1'b1;
        end else begin
          case (phase_q)
            sdinit_pkg::PhCmd0: begin
              phase_d = sdinit_pkg::PhCmd8;
              res_o.cmd_valid = 1'b1;
              res_o.cmd_index = sdinit_pkg::CmdSendIf;
              res_o.cmd_arg = sdinit_pkg::IfPattern;
            end
            sdinit_pkg::PhCmd8: begin
              if ((item_i.rsp_word0 & sdinit_pkg::IfMask) !=
                  (sdinit_pkg::IfPattern & sdinit_pkg::IfMask)) begin
                res_o.status = sdinit_pkg::StInitFail;
                drop = 1'b1;
              end else begin
                rc_d = '0;
                phase_d = sdinit_pkg::PhCmd55;
                res_o.cmd_valid = 1'b1;
                res_o.cmd_index = sdinit_pkg::CmdAppCmd;
              end
            end
            sdinit_pkg::PhCmd55: begin
              phase_d = sdinit_pkg::PhAcmd41;
              res_o.cmd_valid = 1'b1;
              res_o.cmd_index = sdinit_pkg::CmdSdSendOp;
              res_o.cmd_arg = sdinit_pkg::OpArg;
            end
            sdinit_pkg::PhAcmd41: begin
              if (item_i.rsp_word0[sdinit_pkg::OcrBusyBit]) begin
                hc_d = item_i.rsp_word0[sdinit_pkg::OcrCcsBit];
                phase_d = sdinit_pkg::PhCmd2;
                res_o.cmd_valid = 1'b1;
                res_o.cmd_index = sdinit_pkg::CmdAllSendCid;
              end else if (retry_out) begin
                res_o.status = sdinit_pkg::StInitFail;
                drop = 1'b1;
              end else begin
                rc_d = rc_inc;
                phase_d = sdinit_pkg::PhCmd55;
                res_o.cmd_valid = 1'b1;
                res_o.cmd_index = sdinit_pkg::CmdAppCmd;
              end
            end
            sdinit_pkg::PhCmd2: begin
              phase_d = sdinit_pkg::PhCmd3;
              res_o.cmd_valid = 1'b1;
              res_o.cmd_index = sdinit_pkg::CmdSendRca;
            end
            sdinit_pkg::PhCmd3: begin
              rca_d = item_i.rsp_word0[31:16];
              phase_d = sdinit_pkg::PhCmd9;
              res_o.cmd_valid = 1'b1;
              res_o.cmd_index = sdinit_pkg::CmdSendCsd;
              res_o.cmd_arg = {item_i.rsp_word0[31:16], 16'b0};
            end
            sdinit_pkg::PhCmd9: begin
              if (item_i.rsp_word3[31:30] == sdinit_pkg::CsdV2) begin
                cap_d = blocks1;
                phase_d = sdinit_pkg::PhCmd7;
                res_o.cmd_valid = 1'b1;
                res_o.cmd_index = sdinit_pkg::CmdSelect;
                res_o.cmd_arg = {rca_q, 16'b0};
              end else if (item_i.rsp_word3[31:30] == sdinit_pkg::CsdV1) begin
                cap_d = blocks0;
                phase_d = sdinit_pkg::PhCmd7;
                res_o.cmd_valid = 1'b1;
                res_o.cmd_index = sdinit_pkg::CmdSelect;
                res_o.cmd_arg = {rca_q, 16'b0};
              end else begin
                res_o.status = sdinit_pkg::StInitFail;
                drop = 1'b1;
              end
            end
            sdinit_pkg::PhCmd7: begin
              if (!hc_q) begin
                kind_d = sdinit_pkg::KindSdsc;
              end else if (cap_q > sdinit_pkg::XcThreshold) begin
                kind_d = sdinit_pkg::KindSdxc;
              end else begin
                kind_d = sdinit_pkg::KindSdhc;
              end
              phase_d = sdinit_pkg::PhReady;
              res_o.init_done = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      sdinit_pkg::ActAccess: begin
        if (item_i.block_count == '0) begin
          res_o.status = sdinit_pkg::StBadArg;
        end else if (phase_q != sdinit_pkg::PhReady) begin
          res_o.status = sdinit_pkg::StBadState;
        end else if (range_end > {1'b0, cap_q}) begin
          res_o.status = sdinit_pkg::StRange;
        end else begin
          res_o.card_address = (kind_q == sdinit_pkg::KindSdsc) ?
                               {item_i.lba[22:0], 9'b0} : item_i.lba;
          res_o.access_write = item_i.is_write;
        end
      end
      sdinit_pkg::ActDeinit: begin
        drop = 1'b1;
        kind_d = sdinit_pkg::KindUnknown;
      end
      default: begin
      end
    endcase

    if (drop) begin
      phase_d = restart ? sdinit_pkg::PhCmd0 : sdinit_pkg::PhIdle;
      rc_d = '0;
      rca_d = '0;
      cap_d = '0;
      hc_d = 1'b0;
    end

    ready_d = (phase_d == sdinit_pkg::PhReady);
    if (ready_d) begin
      res_o.card_kind = kind_d;
      res_o.capacity = cap_d;
      res_o.card_rca = rca_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sdinit_pkg::RetryLimitRst;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdinit_pkg::PhIdle;
      rc_q <= '0;
      rca_q <= '0;
      cap_q <= '0;
      hc_q <= 1'b0;
      kind_q <= sdinit_pkg::KindUnknown;
    end else if (fire_i) begin
      phase_q <= phase_d;
      rc_q <= rc_d;
      rca_q <= rca_d;
      cap_q <= cap_d;
      hc_q <= hc_d;
      kind_q <= kind_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sdinit_out_reg.sv
// Result register stage of the SD card initialization sequencer.
// Depends on sdinit_pkg for the result word type.
`default_nettype none

module sdinit_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire sdinit_pkg::result_t res_i,
  output logic                     can_load_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sdinit_pkg::result_t      res_o
);

  logic                valid_q;
  sdinit_pkg::result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

// File: hdl/sd_card_init_sequencer.sv
// Top level of the SD card initialization sequencer.
// Depends on sdinit_pkg, sdinit_in_reg, sdinit_core and sdinit_out_reg.
//
// Usage: each input word (in_valid_i/in_ready_o) is a start, a command
// response, an access request or a deinit, and yields exactly one result
// word (out_valid_o/out_ready_i) with the next command to issue, a status
// code, the card data once initialized and the translated access address.
// The word is captured in an input register; the decision logic then writes
// the result register and updates the sequencer state once the result
// register can load, and out_valid_o rises when the result register is full.
// Throughput is one word per cycle while the receiver keeps out_ready_i
// high, limited by the single decision stage between the two registers.
// When the receiver stalls, the result holds, one more word may wait in
// the input register, and in_ready_o then drops until the result is taken.
// Reset empties both registers, sets the sequencer idle with no card data
// and loads the ACMD41 retry limit with 1000. The retry limit must be written
// by the user through cfg_we_i/cfg_data_i only while no word is in flight;
// the block itself does not enforce this.
`default_nettype none

module sd_card_init_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic        rsp_error_i,
  input  wire logic [31:0] rsp_word0_i,
  input  wire logic [31:0] rsp_word1_i,
  input  wire logic [31:0] rsp_word2_i,
  input  wire logic [31:0] rsp_word3_i,
  input  wire logic [31:0] lba_i,
  input  wire logic [31:0] block_count_i,
  input  wire logic        is_write_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             cmd_valid_o,
  output logic [5:0]       cmd_index_o,
  output logic [31:0]      cmd_arg_o,
  output logic [2:0]       status_o,
  output logic             init_done_o,
  output logic [1:0]       card_kind_o,
  output logic [31:0]      capacity_o,
  output logic [15:0]      card_rca_o,
  output logic [31:0]      card_address_o,
  output logic             access_write_o
);

  sdinit_pkg::item_t   in_item;
  sdinit_pkg::item_t   s1_item;
  sdinit_pkg::result_t core_res;
  sdinit_pkg::result_t out_res;
  logic                s1_valid;
  logic                can_load;
  logic                fire;

  always_comb begin
    in_item.action = sdinit_pkg::action_e'(action_i);
    in_item.rsp_error = rsp_error_i;
    in_item.rsp_word0 = rsp_word0_i;
    in_item.rsp_word1 = rsp_word1_i;
    in_item.rsp_word2 = rsp_word2_i;
    in_item.rsp_word3 = rsp_word3_i;
    in_item.lba = lba_i;
    in_item.block_count = block_count_i;
    in_item.is_write = is_write_i;
  end

  assign fire = s1_valid && can_load;

  sdinit_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .down_ready_i (can_load),
    .valid_o      (s1_valid),
    .item_o       (s1_item)
  );

  sdinit_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (s1_item),
    .res_o      (core_res)
  );

  sdinit_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (core_res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign cmd_valid_o = out_res.cmd_valid;
  assign cmd_index_o = out_res.cmd_index;
  assign cmd_arg_o = out_res.cmd_arg;
  assign status_o = out_res.status;
  assign init_done_o = out_res.init_done;
  assign card_kind_o = out_res.card_kind;
  assign capacity_o = out_res.capacity;
  assign card_rca_o = out_res.card_rca;
  assign card_address_o = out_res.card_address;
  assign access_write_o = out_res.access_write;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid && out_valid_o && !out_ready_i)
    else $error("input stalled while the result path is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cmd_valid_o |-> cmd_index_o == '0 && cmd_arg_o == '0)
    else $error("command fields set without a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && init_done_o |->
      status_o == sdinit_pkg::StOk && card_kind_o != sdinit_pkg::KindUnknown)
    else $error("initialization finished without a card kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && access_write_o |-> status_o == sdinit_pkg::StOk &&
      card_kind_o != sdinit_pkg::KindUnknown)
    else $error("access granted while not ready or with an error");

endmodule

`default_nettype wire
